/* src/lzwc_pkg.sv */
package lzwc_pkg;

  localparam int MAX_BITS   = 16;
  localparam int SLOT_BITS  = 17;
  localparam int EPOCH_BITS = 4;
  localparam int ACC_BITS   = 7 + MAX_BITS;

  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_DATA   = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;

  localparam logic [4:0] CFG_RESET  = 5'd12;
  localparam logic [4:0] WIDTH_MIN  = 5'd9;
  localparam logic [MAX_BITS-1:0] FIRST_FREE = MAX_BITS'(256);

  typedef struct packed {
    logic [EPOCH_BITS-1:0] epoch;
    logic [23:0]           pair;
    logic [MAX_BITS-1:0]   code;
  } slot_t;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic probe_next;
    logic take_hit;
    logic miss;
    logic put;
    logic emit;
    logic emit_flush;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic epoch_last;
    logic hit;
    logic empty;
    logic acc_ge8;
    logic acc_zero;
    logic q_more;
    logic q_flush;
    logic q_restart;
    logic out_free;
  } dp_status_t;

endpackage

/* src/lzw_compressor_variable_width.sv */
// lzw compressor with growing code width, bytes in, packed code stream out
// channels:
//   s_axis: one item per input byte; tuser = command (start/data/finish),
//     tdata = the byte; a start clears the dictionary and takes its byte as prefix
//   m_axis: packed code bytes, msb first; tlast marks the final byte of an item
//   cfg: write of max_code_bits (5 bits, reset 12, saturated to 9..16), always ready
// timing:
//   each hash probe of a data byte is a read state then a check state (slot table
//   read is registered); a hit goes back to idle from the check state; each code
//   is loaded in the put state and drained in the drain state, which emits an
//   output byte whenever the output register is free
//   input is taken only when the previous item is fully drained into the output
//   register; one finished byte may still wait there while the next item enters
// reset:
//   synchronous rst; afterwards a clear pass sweeps all 131072 slot table entries
//   before the first item is taken; every 15th dictionary restart wraps the
//   epoch mark and repeats that pass (config writes are still taken)
// stall:
//   while m_axis_tready is low the output byte holds; the next emit waits for it
module lzw_compressor_variable_width (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data
);
  import lzwc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t st;

  // config register is a plain flop, so writes are never stalled
  assign cfg_ready = 1'b1;

  lzwc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_cmd   (s_axis_tuser),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  lzwc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_cmd    (s_axis_tuser),
    .in_byte   (s_axis_tdata),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_byte  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

/* src/lzwc_ctrl.sv */
module lzwc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [1:0]          in_cmd,
  output logic                in_ready,
  input  lzwc_pkg::dp_status_t st,
  output lzwc_pkg::ctrl_cmd_t  cmd
);
  import lzwc_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_READ  = 7'b0000100,
    S_CHECK = 7'b0001000,
    S_PUT   = 7'b0010000,
    S_DRAIN = 7'b0100000,
    S_FLUSH = 7'b1000000
  } state_t;

  state_t state, state_next;
  state_t done_state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // after an item ends, a restart that wraps the epoch needs a clear pass
  assign done_state = (st.q_restart && st.epoch_last) ? S_CLEAR : S_IDLE;

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (in_cmd)
            CMD_START:  state_next = st.epoch_last ? S_CLEAR : S_IDLE;
            CMD_DATA:   state_next = S_READ;
            CMD_FINISH: state_next = S_PUT;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_READ: state_next = S_CHECK;
      S_CHECK: begin
        if (st.hit) begin
          cmd.take_hit = 1'b1;
          state_next   = S_IDLE;
        end else if (st.empty) begin
          cmd.miss   = 1'b1;
          state_next = S_PUT;
        end else begin
          cmd.probe_next = 1'b1;
          state_next     = S_READ;
        end
      end
      S_PUT: begin
        cmd.put    = 1'b1;
        state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (st.acc_ge8) begin
          cmd.emit = st.out_free;
        end else if (st.q_more) begin
          state_next = S_PUT;
        end else if (st.q_flush && !st.acc_zero) begin
          state_next = S_FLUSH;
        end else begin
          cmd.finish = 1'b1;
          state_next = done_state;
        end
      end
      S_FLUSH: begin
        if (st.out_free) begin
          cmd.emit_flush = 1'b1;
          cmd.finish     = 1'b1;
          state_next     = done_state;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.take_hit, cmd.miss, cmd.put, cmd.emit, cmd.clr_step}))
    else $error("controller issued two commands at once");

  a_read_then_check: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> (state == S_CHECK))
    else $error("probe read not followed by check");

  a_put_drain: assert property (@(posedge clk) disable iff (rst)
    cmd.put |=> (state == S_DRAIN))
    else $error("code load not followed by drain");

endmodule

/* src/lzwc_datapath.sv */
module lzwc_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [1:0]           in_cmd,
  input  logic [7:0]           in_byte,
  input  logic                 cfg_valid,
  input  logic [4:0]           cfg_data,
  input  lzwc_pkg::ctrl_cmd_t  cmd,
  output lzwc_pkg::dp_status_t st,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [7:0]           out_byte,
  output logic                 out_last
);
  import lzwc_pkg::*;

  slot_t mem [0:(1<<SLOT_BITS)-1];
  slot_t rd_q;
  slot_t wr_data;
  logic  wr_en;

  logic [EPOCH_BITS-1:0] epoch;
  logic [SLOT_BITS-1:0]  slot;
  logic [SLOT_BITS-1:0]  clr_addr;
  logic [23:0]           pair_q;
  logic [7:0]            byte_q;
  logic [MAX_BITS-1:0]   prefix;
  logic [MAX_BITS-1:0]   nfc;
  logic [4:0]            width;
  logic [ACC_BITS-1:0]   acc;
  logic [4:0]            acnt;
  logic [4:0]            max_bits;
  logic [MAX_BITS-1:0]   q_code [0:1];
  logic [4:0]            q_w [0:1];
  logic [1:0]            q_n;
  logic                  q_flush;
  logic                  q_restart;

  logic [4:0]          bits_sat;
  logic [MAX_BITS:0]   lim;
  logic [MAX_BITS:0]   width_top;
  logic                full;
  logic [23:0]         in_pair;
  logic [SLOT_BITS-1:0] in_slot;
  logic                slot_valid;
  logic [ACC_BITS-1:0] acc_put;
  logic [ACC_BITS-1:0] acc_shift;
  logic [7:0]          flush_byte;
  logic                restart;
  logic [MAX_BITS-1:0] fin_marker;

  function automatic logic [MAX_BITS-1:0] mask_code(logic [MAX_BITS:0] v, logic [4:0] w);
    logic [MAX_BITS:0] m;
    m = (MAX_BITS+1)'((MAX_BITS+1)'(1) << w) - (MAX_BITS+1)'(1);
    return MAX_BITS'(v & m);
  endfunction

  assign bits_sat  = (max_bits < WIDTH_MIN) ? WIDTH_MIN :
                     (max_bits > 5'(MAX_BITS)) ? 5'(MAX_BITS) : max_bits;
  assign lim       = ((MAX_BITS+1)'(1) << bits_sat) - (MAX_BITS+1)'(1);
  assign width_top = ((MAX_BITS+1)'(1) << width) - (MAX_BITS+1)'(1);
  assign full      = {1'b0, nfc} >= lim;
  assign in_pair   = {prefix, in_byte};
  assign in_slot   = in_pair[SLOT_BITS-1:0] ^ SLOT_BITS'(in_pair[23:SLOT_BITS]);
  assign slot_valid = (rd_q.epoch == epoch);
  assign fin_marker = mask_code(width_top, width);

  assign acc_put   = ACC_BITS'(({{(ACC_BITS-7){1'b0}}, acc[6:0]} << q_w[0])
                     | ACC_BITS'(q_code[0]));
  assign acc_shift = acc >> (acnt - 5'd8);
  assign flush_byte = 8'(acc[7:0] << (5'd8 - acnt));
  assign restart   = cmd.finish && q_restart;

  always_comb begin
    st.clr_done   = (clr_addr == '1);
    st.epoch_last = (epoch == '1);
    st.hit        = slot_valid && (rd_q.pair == pair_q);
    st.empty      = !slot_valid;
    st.acc_ge8    = (acnt >= 5'd8);
    st.acc_zero   = (acnt == 5'd0);
    st.q_more     = (q_n != 2'd0);
    st.q_flush    = q_flush;
    st.q_restart  = q_restart;
    st.out_free   = !out_valid || out_ready;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_data = '0;
    if (cmd.clr_step) begin
      wr_en = 1'b1;
    end else if (cmd.miss && !full) begin
      wr_en   = 1'b1;
      wr_data = '{epoch: epoch, pair: pair_q, code: nfc};
    end
  end

  // slot table
  always_ff @(posedge clk) begin
    if (wr_en) mem[cmd.clr_step ? clr_addr : slot] <= wr_data;
    rd_q <= mem[slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_bits <= CFG_RESET;
    end else if (cfg_valid) begin
      max_bits <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      epoch     <= '0;
      clr_addr  <= '0;
      prefix    <= '0;
      nfc       <= FIRST_FREE;
      width     <= WIDTH_MIN;
      acc       <= '0;
      acnt      <= '0;
      q_n       <= '0;
      q_flush   <= 1'b0;
      q_restart <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.clr_step) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == '1) epoch <= EPOCH_BITS'(1);
      end
      if (cmd.load) begin
        pair_q    <= in_pair;
        byte_q    <= in_byte;
        slot      <= in_slot;
        q_restart <= 1'b0;
        if (in_cmd == CMD_START) begin
          epoch  <= epoch + 1'b1;
          prefix <= MAX_BITS'(in_byte);
          nfc    <= FIRST_FREE;
          width  <= WIDTH_MIN;
          acc    <= '0;
          acnt   <= '0;
        end else if (in_cmd == CMD_FINISH) begin
          q_code[0] <= prefix;
          q_w[0]    <= width;
          q_code[1] <= fin_marker;
          q_w[1]    <= width;
          q_n       <= 2'd2;
          q_flush   <= 1'b1;
        end
      end
      if (cmd.probe_next) slot <= slot + 1'b1;
      if (cmd.take_hit) prefix <= rd_q.code;
      if (cmd.miss) begin
        prefix <= MAX_BITS'(byte_q);
        if (full) begin
          q_code[0] <= mask_code({1'b0, prefix}, width);
          q_w[0]    <= width;
          q_code[1] <= mask_code(lim, width);
          q_w[1]    <= width;
          q_n       <= 2'd2;
          q_flush   <= 1'b1;
          q_restart <= 1'b1;
        end else begin
          nfc     <= nfc + 1'b1;
          q_flush <= 1'b0;
          if ({1'b0, nfc} == width_top) begin
            // marker code at the old width, then the width grows
            q_code[0] <= nfc;
            q_w[0]    <= width;
            q_code[1] <= mask_code({1'b0, prefix}, width + 5'd1);
            q_w[1]    <= width + 5'd1;
            q_n       <= 2'd2;
            width     <= width + 5'd1;
          end else begin
            q_code[0] <= mask_code({1'b0, prefix}, width);
            q_w[0]    <= width;
            q_n       <= 2'd1;
          end
        end
      end
      if (cmd.put) begin
        acc       <= acc_put;
        acnt      <= acnt + q_w[0];
        q_code[0] <= q_code[1];
        q_w[0]    <= q_w[1];
        q_n       <= q_n - 2'd1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
        out_byte  <= acc_shift[7:0];
        out_last  <= (acnt < 5'd16) && (q_n == 2'd0) && (!q_flush || acnt == 5'd8);
        acnt      <= acnt - 5'd8;
      end
      if (cmd.emit_flush) begin
        out_valid <= 1'b1;
        out_byte  <= flush_byte;
        out_last  <= 1'b1;
        acc       <= '0;
        acnt      <= '0;
      end
      if (restart) begin
        epoch <= epoch + 1'b1;
        nfc   <= FIRST_FREE;
        width <= WIDTH_MIN;
        acc   <= '0;
        acnt  <= '0;
      end
    end
  end

  a_idle_partial: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (acnt < 5'd8))
    else $error("more than seven bits pending between items");

  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit || cmd.emit_flush) |-> (!out_valid || out_ready))
    else $error("output register overwritten");

  a_code_advance: assert property (@(posedge clk) disable iff (rst)
    (cmd.miss && !full) |=> (nfc == $past(nfc) + 1'b1))
    else $error("free code did not advance on insert");

  a_queue_depth: assert property (@(posedge clk) disable iff (rst)
    q_n <= 2'd2)
    else $error("code queue overrun");

endmodule

/* test/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lzwc_pkg::*;

  // command code that the block ignores
  localparam logic [1:0] CMD_IGNORED = 2'd3;
  // cycles without any item accepted before the run is given up;
  // covers the slot-table clear pass after restarts plus the long output hold
  localparam int IDLE_LIMIT = 500000;
  // quiet time after the last expected byte; covers a long probe chain
  localparam int SETTLE_CYCLES = 300;

  typedef struct {
    logic [7:0] out_byte;
    logic       last;
  } code_byte_t;

  // lzw predictor plus the queue of code bytes it still expects
  class lzw_scoreboard;
    int unsigned dict[int unsigned];   // (prefix, byte) pair -> code
    int unsigned prefix, free_code, width, bits, nbits;
    logic [4:0]  max_bits;
    code_byte_t  expected_q[$];
    code_byte_t  staged[$];
    int          errors;

    function new();
      max_bits = CFG_RESET;
      prefix = 0;
      errors = 0;
      clear_dict();
    endfunction

    function void clear_dict();
      dict.delete();
      free_code = 256;
      width = WIDTH_MIN;
      bits = 0;
      nbits = 0;
    endfunction

    function void set_max_bits(logic [4:0] v);
      max_bits = v;
    endfunction

    function int unsigned table_limit();
      int unsigned b;
      b = max_bits;
      if (b < 9) b = 9;
      if (b > MAX_BITS) b = MAX_BITS;
      return (1 << b) - 1;
    endfunction

    function void pack_code(int unsigned value);
      int unsigned acc;
      value &= (1 << width) - 1;
      acc = ((bits & 255) << width) | value;
      nbits = (nbits & 7) + width;
      while (nbits >= 8) begin
        if (staged.size() < 6) staged.push_back('{out_byte: 8'(acc >> (nbits - 8)), last: 1'b0});
        nbits -= 8;
      end
      bits = acc & ((1 << nbits) - 1);
    endfunction

    function void flush_partial();
      int unsigned c;
      c = nbits & 7;
      if (c != 0 && staged.size() < 6)
        staged.push_back('{out_byte: 8'((bits << (8 - c)) & 255), last: 1'b0});
      bits = 0;
      nbits = 0;
    endfunction

    function void note_input(logic [1:0] cmd, logic [7:0] data);
      int unsigned pair, lim;
      staged.delete();
      case (cmd)
        CMD_START: begin
          clear_dict();
          prefix = data;
        end
        CMD_DATA: begin
          pair = ((prefix & 16'hffff) << 8) | data;
          if (dict.exists(pair)) begin
            prefix = dict[pair];
          end else begin
            lim = table_limit();
            if (free_code >= lim) begin
              // table full: prefix, reset code, flush, fresh dictionary
              pack_code(prefix);
              pack_code(lim);
              flush_partial();
              clear_dict();
              prefix = data;
            end else begin
              if (free_code == (1 << width) - 1) begin
                pack_code(free_code);
                width++;
              end
              dict[pair] = free_code;
              free_code++;
              pack_code(prefix);
              prefix = data;
            end
          end
        end
        CMD_FINISH: begin
          pack_code(prefix);
          pack_code((1 << width) - 1);
          flush_partial();
        end
        default: ;
      endcase
      if (staged.size() > 0) staged[staged.size() - 1].last = 1'b1;
      foreach (staged[i]) expected_q.push_back(staged[i]);
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [7:0] out_byte, logic last);
      code_byte_t exp_item;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected code byte %02h last %0b", out_byte, last));
      end else begin
        exp_item = expected_q.pop_front();
        if (out_byte !== exp_item.out_byte)
          report($sformatf("out_byte %02h, expected %02h", out_byte, exp_item.out_byte));
        if (last !== exp_item.last)
          report($sformatf("last %0b, expected %0b", last, exp_item.last));
      end
    endtask
  endclass

  logic       clk;
  logic       rst;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [7:0] data_byte
  logic [1:0] s_axis_tuser;   // [1:0] command
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // [7:0] out_byte
  logic       m_axis_tlast;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [4:0] cfg_data;

  lzw_compressor_variable_width dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  lzw_scoreboard sb = new();

  int  bytes_sent = 0;
  int  codes_seen = 0;
  int  idle_cycles = 0;
  bit  long_hold_done = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: no item accepted on any channel for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // receiver: random gaps per code byte, bursts with none, one long hold
  initial begin
    int gap;
    m_axis_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    m_axis_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata, m_axis_tlast);
        codes_seen++;
        if (!long_hold_done && codes_seen >= 100) begin
          // sender keeps pushing while we stall, so the block backs up
          gap = 600;
          long_hold_done = 1;
        end else if ((codes_seen / 48) % 3 == 2) begin
          gap = 0;
        end else begin
          gap = $urandom_range(0, 9);
        end
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk);
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  // offer one item, wait for the handshake, then feed the predictor
  task send_item(logic [1:0] cmd, logic [7:0] data);
    int gap;
    gap = ((bytes_sent / 40) % 4 == 3) ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= data;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(cmd, data);
    bytes_sent++;
  endtask

  // wait for every expected byte, then let hits or starts settle
  task drain();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_max_bits(logic [4:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_max_bits(v);
  endtask

  // text-like bytes half the time so the dictionary gets hits
  function logic [7:0] pick_byte();
    return ($urandom_range(0, 1) == 1) ? 8'(8'h41 + $urandom_range(0, 3))
                                       : 8'($urandom_range(0, 255));
  endfunction

  task random_run(int count);
    int k;
    int unsigned r;
    for (k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 4) send_item(CMD_START, pick_byte());
      else if (r < 9) send_item(CMD_FINISH, 8'($urandom_range(0, 255)));
      else if (r < 12) send_item(CMD_IGNORED, 8'($urandom_range(0, 255)));
      else send_item(CMD_DATA, pick_byte());
    end
  endtask

  initial begin
    int k;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    s_axis_tuser  <= CMD_START;
    cfg_valid     <= 1'b0;
    cfg_data      <= CFG_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: data before any start, ignored command, start dropping bits,
    // hit, miss, double finish, data after finish, byte extremes
    send_item(CMD_DATA, 8'h00);
    send_item(CMD_IGNORED, 8'hff);
    send_item(CMD_START, 8'hff);
    send_item(CMD_DATA, 8'hff);
    send_item(CMD_DATA, 8'hff);
    send_item(CMD_DATA, 8'hff);
    send_item(CMD_FINISH, 8'h00);
    send_item(CMD_FINISH, 8'hff);
    send_item(CMD_DATA, 8'h00);
    send_item(CMD_START, 8'h80);
    send_item(CMD_DATA, 8'h01);
    send_item(CMD_DATA, 8'h7f);
    send_item(CMD_DATA, 8'h80);
    send_item(CMD_DATA, 8'h01);
    send_item(CMD_DATA, 8'h7f);
    send_item(CMD_DATA, 8'h80);
    send_item(CMD_FINISH, 8'h55);
    drain();

    // above range saturates to 16: grow past 511 so the width steps up
    write_max_bits(5'd31);
    send_item(CMD_START, 8'h00);
    for (k = 0; k < 270; k++) send_item(CMD_DATA, 8'($urandom_range(0, 255)));
    drain();

    // below range saturates to 9: table now over the limit, reset sequence
    write_max_bits(5'd0);
    for (k = 0; k < 16; k++) send_item(CMD_DATA, pick_byte());
    send_item(CMD_FINISH, 8'h00);
    drain();

    write_max_bits(5'd12);
    random_run(80);
    drain();

    write_max_bits(5'd9);
    send_item(CMD_START, 8'h41);
    random_run(40);
    send_item(CMD_FINISH, 8'h00);
    drain();

    write_max_bits(5'd16);
    random_run(30);
    send_item(CMD_FINISH, 8'h00);
    drain();

    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
